// ----- hw/rtl/positional_list_store_assert.svh -----
// Assertion helpers for the positional list store checks.
// Both expect clk and rst_n to be visible where they are used.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_list_store check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_list_store check failed");

`endif

// ----- hw/rtl/pls_pkg.sv -----
package pls_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = 5;
    localparam int POS_W       = 5;
    localparam int OP_W        = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef logic signed [VALUE_WIDTH-1:0] word_t;

    // Command broadcast to every cell of the row in the cycle a request is taken.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic             rd;
        logic [IDX_W-1:0] slot;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/pls_if.sv -----
interface pls_req_if;
    import pls_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [POS_W-1:0]     position;
    word_t                value;

    modport source (output valid, op, position, value, input ready);
    modport sink   (input valid, op, position, value, output ready);
endinterface

interface pls_rsp_if;
    import pls_pkg::*;

    logic                 valid;
    logic                 ready;
    word_t                read_value;
    logic [CNT_W-1:0]     entry_count;
    logic                 is_empty;
    logic                 error;

    modport source (output valid, read_value, entry_count, is_empty, error, input ready);
    modport sink   (input valid, read_value, entry_count, is_empty, error, output ready);
endinterface

// ----- hw/rtl/pls_cell.sv -----
module pls_cell (
    input  logic                      clk,
    input  pls_pkg::cell_cmd_t        cmd,
    input  logic [pls_pkg::IDX_W-1:0] idx,
    input  pls_pkg::word_t            ins_value,
    input  pls_pkg::word_t            left_data,
    input  pls_pkg::word_t            right_data,
    output pls_pkg::word_t            data,
    output pls_pkg::word_t            tap
);
    import pls_pkg::*;

    word_t data_reg;
    word_t data_next;
    logic  at_slot;
    logic  above_slot;

    assign at_slot    = (idx == cmd.slot);
    assign above_slot = (idx > cmd.slot);

    // An insert opens a gap at the slot by pulling from the left neighbor;
    // a remove closes it by pulling from the right neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (at_slot)
                data_next = ins_value;
            else if (above_slot)
                data_next = left_data;
        end
        else if (cmd.rem)
        begin
            if (at_slot || above_slot)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (cmd.rd && at_slot) ? data_reg : '0;

endmodule

// ----- hw/rtl/positional_list_store.sv -----
// Channel | Direction | Handshake   | Payload
// req     | in        | valid/ready | op, position, value
// rsp     | out       | valid/ready | read_value, entry_count, is_empty, error
//
// Every accepted request gives one response item in the following cycle.
// One request per cycle is sustained while rsp.ready is high; the cell row, updated in
// the cycle a request is taken, and the response register set that figure.
// req.ready is low only while a response waits and rsp.ready is low.
// Reset clears the entry count and the response valid flag; cell contents
// are left as they are, since only cells below the count are ever read.
module positional_list_store (
    input  logic clk,
    input  logic rst_n,
    pls_req_if.sink   req,
    pls_rsp_if.source rsp
);
    import pls_pkg::*;

    // Cell row: position p lives in cell p-1. Each cell sees the broadcast
    // command and its two neighbors and updates itself in the same cycle.
    cell_cmd_t        cmd;
    word_t            cell_data [CAPACITY];
    word_t            cell_tap  [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             rsp_valid_reg;
    word_t            read_value_reg;
    logic [CNT_W-1:0] entry_count_reg;
    logic             is_empty_reg;
    logic             error_reg;

    logic             accept;
    logic [POS_W-1:0] pos_m1;
    logic             pos_zero;
    logic             pos_in_list;
    logic             pos_ins_ok;
    logic             has_room;
    logic             err;
    word_t            tap_or;

    // The response register decouples the sides: a new request is taken
    // whenever the held response is absent or leaves in this cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_m1      = req.position - POS_W'(1);
    assign pos_zero    = (req.position == '0);
    assign pos_in_list = !pos_zero && (req.position <= count_reg);
    assign pos_ins_ok  = !pos_zero
                         && ({1'b0, req.position} <= ({1'b0, count_reg} + (CNT_W+1)'(1)));
    assign has_room    = (count_reg < CNT_W'(CAPACITY));

    // Decode the request into a row command and the new count. A rejected
    // request sends no command, so the row and the count stay as they are.
    always_comb
    begin
        cmd        = '0;
        cmd.slot   = IDX_W'(pos_m1);
        count_next = count_reg;
        err        = 1'b0;
        case (req.op)
            OP_INSERT:
            begin
                if (pos_ins_ok && has_room)
                begin
                    cmd.ins    = accept;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                    err = 1'b1;
            end
            OP_REMOVE:
            begin
                if (pos_in_list)
                begin
                    cmd.rem    = accept;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                    err = 1'b1;
            end
            OP_READ:
            begin
                if (pos_in_list)
                    cmd.rd = accept;
                else
                    err = 1'b1;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            word_t left_in;
            word_t right_in;

            if (g == 0)
            begin : g_first
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[g];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[g+1];
            end

            pls_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .idx        (IDX_W'(g)),
                .ins_value  (req.value),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[g]),
                .tap        (cell_tap[g])
            );
        end
    endgenerate

    // Only the addressed cell drives a nonzero tap on a valid read.
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            tap_or = tap_or | cell_tap[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg  <= tap_or;
            entry_count_reg <= count_next;
            is_empty_reg    <= (count_next == '0);
            error_reg       <= err;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.is_empty    = is_empty_reg;
    assign rsp.error       = error_reg;

endmodule

// ----- hw/rtl/pls_checker.sv -----
`include "positional_list_store_assert.svh"

module pls_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input pls_pkg::word_t            read_value,
    input logic [pls_pkg::CNT_W-1:0] entry_count,
    input logic                      is_empty,
    input logic                      error
);
    import pls_pkg::*;

    // A stalled response keeps its payload.
    `PLS_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(entry_count) && $stable(read_value))
    // Every accepted request is answered in the next cycle.
    `PLS_ASSERT_NEXT(a_rsp_follows, in_valid && in_ready, out_valid)
    // The empty flag agrees with the count.
    `PLS_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (entry_count == '0))
    // The count never exceeds the row length.
    `PLS_ASSERT_NOW(a_count_cap, out_valid, entry_count <= CNT_W'(CAPACITY))
    // A rejected request reads as zero.
    `PLS_ASSERT_NOW(a_err_zero, out_valid && error, read_value == '0)

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count),
    .is_empty    (rsp.is_empty),
    .error       (rsp.error)
);
